// File: src/swp_pkg.sv
// Shared types and constants for the sphere wall push-out block.
// No dependencies; imported by every module of the block but swp_ram.
`default_nettype none

package swp_pkg;

    // default configuration
    localparam int MAX_WALLS_DEF    = 1024;
    localparam int THICKNESS_DEF    = 26;

    // grid geometry in Q8.8
    localparam int CELL_SH          = 8;
    localparam int CELL_Q8          = 1 << CELL_SH;
    localparam int HEIGHT_Q8        = 256;

    // internal coordinate width: covers the maze plus thickness and radius
    localparam int PW               = 18;
    // radius field width; a gap of 2**RW or more can never be a hit
    localparam int RW               = 9;

    // stored wall: cell_x [5:0], cell_y [11:6], side [13:12]
    localparam int CXW              = 6;
    localparam int ENTRY_W          = 14;

    // action codes
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ADD     = 2'd1;
    localparam logic [1:0] ACT_RESOLVE = 2'd2;

    // side codes
    localparam logic [1:0] SIDE_N   = 2'd0;
    localparam logic [1:0] SIDE_S   = 2'd1;
    localparam logic [1:0] SIDE_W   = 2'd2;
    localparam logic [1:0] SIDE_E   = 2'd3;

    typedef struct packed {
        logic signed [PW-1:0] x0;
        logic signed [PW-1:0] x1;
        logic signed [PW-1:0] z0;
        logic signed [PW-1:0] z1;
    } box_t;

    typedef struct packed {
        logic start;   // load a new sphere
        logic eval;    // a decoded box is present
    } push_ctl_t;

endpackage

`default_nettype wire

// File: src/swp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module swp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/swp_box_decode.sv
// Registered decode of a stored wall entry into its x/z box bounds.
// Depends on swp_pkg.
`default_nettype none

module swp_box_decode #(
    parameter int THICKNESS_Q8 = swp_pkg::THICKNESS_DEF
) (
    input  wire logic                         clk,
    input  wire logic [swp_pkg::ENTRY_W-1:0]  entry,
    output swp_pkg::box_t                     box
);

    import swp_pkg::*;

    localparam logic signed [PW-1:0] T_Q = PW'(THICKNESS_Q8);
    localparam logic signed [PW-1:0] C_Q = PW'(CELL_Q8);

    logic signed [PW-1:0] fx;
    logic signed [PW-1:0] fz;
    logic [1:0]           side;
    box_t                 box_next;
    box_t                 box_reg;

    always_comb
    begin
        fx   = signed'(PW'(entry[CXW-1:0]) << CELL_SH);
        fz   = signed'(PW'(entry[2*CXW-1:CXW]) << CELL_SH);
        side = entry[ENTRY_W-1:2*CXW];
        case (side)
            SIDE_N:
            begin
                box_next.x0 = fx;
                box_next.x1 = fx + C_Q;
                box_next.z0 = fz - T_Q;
                box_next.z1 = fz;
            end
            SIDE_S:
            begin
                box_next.x0 = fx;
                box_next.x1 = fx + C_Q;
                box_next.z0 = fz + C_Q;
                box_next.z1 = fz + C_Q + T_Q;
            end
            SIDE_W:
            begin
                box_next.x0 = fx - T_Q;
                box_next.x1 = fx;
                box_next.z0 = fz;
                box_next.z1 = fz + C_Q;
            end
            default:
            begin
                box_next.x0 = fx + C_Q;
                box_next.x1 = fx + C_Q + T_Q;
                box_next.z0 = fz;
                box_next.z1 = fz + C_Q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box = box_reg;

endmodule

`default_nettype wire

// File: src/swp_push_unit.sv
// Sphere state and per-wall intersection test with push-out, one box a cycle.
// Depends on swp_pkg.
`default_nettype none

module swp_push_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire swp_pkg::push_ctl_t          ctl,
    input  wire logic signed [15:0]          init_x,
    input  wire logic signed [15:0]          init_y,
    input  wire logic signed [15:0]          init_z,
    input  wire logic [swp_pkg::RW-1:0]      init_r,
    input  wire swp_pkg::box_t               box,
    output logic signed [swp_pkg::PW-1:0]    px,
    output logic signed [swp_pkg::PW-1:0]    pz,
    output logic                             hit
);

    import swp_pkg::*;

    localparam logic signed [PW-1:0] Y_LO = '0;
    localparam logic signed [PW-1:0] Y_HI = PW'(HEIGHT_Q8);

    logic signed [PW-1:0] px_reg, px_next;
    logic signed [PW-1:0] pz_reg, pz_next;
    logic signed [PW-1:0] py_reg, py_next;
    logic [RW-1:0]        r_reg, r_next;
    logic [2*RW-1:0]      r2_reg, r2_next;
    logic                 hit_reg, hit_next;

    logic [RW:0]          gx, gy, gz;
    logic [2*RW+1:0]      d2;
    logic                 contact;
    logic signed [PW:0]   left, right, front, back, m;
    logic signed [PW-1:0] rs;

    // far flag on top, clipped gap magnitude below
    function automatic logic [RW:0] gap(input logic signed [PW-1:0] c,
                                        input logic signed [PW-1:0] lo,
                                        input logic signed [PW-1:0] hi);
        logic signed [PW:0] d;
        logic [PW:0]        a;
        if (c < lo)
        begin
            d = (PW+1)'(c) - (PW+1)'(lo);
        end
        else if (c > hi)
        begin
            d = (PW+1)'(c) - (PW+1)'(hi);
        end
        else
        begin
            d = '0;
        end
        a = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
        return {(|a[PW:RW]), a[RW-1:0]};
    endfunction

    always_comb
    begin
        gx = gap(px_reg, box.x0, box.x1);
        gy = gap(py_reg, Y_LO, Y_HI);
        gz = gap(pz_reg, box.z0, box.z1);
        d2 = (2*RW+2)'(gx[RW-1:0] * gx[RW-1:0])
           + (2*RW+2)'(gy[RW-1:0] * gy[RW-1:0])
           + (2*RW+2)'(gz[RW-1:0] * gz[RW-1:0]);
        contact = !gx[RW] && !gy[RW] && !gz[RW] && (d2 < (2*RW+2)'(r2_reg));

        left  = (PW+1)'(px_reg) - (PW+1)'(box.x0);
        right = (PW+1)'(box.x1) - (PW+1)'(px_reg);
        front = (PW+1)'(pz_reg) - (PW+1)'(box.z0);
        back  = (PW+1)'(box.z1) - (PW+1)'(pz_reg);
        m = left;
        if (right < m) m = right;
        if (front < m) m = front;
        if (back < m)  m = back;
        rs = signed'(PW'(r_reg));

        px_next  = px_reg;
        pz_next  = pz_reg;
        py_next  = py_reg;
        r_next   = r_reg;
        r2_next  = r2_reg;
        hit_next = hit_reg;
        if (ctl.start)
        begin
            px_next  = PW'(init_x);
            py_next  = PW'(init_y);
            pz_next  = PW'(init_z);
            r_next   = init_r;
            r2_next  = init_r * init_r;
            hit_next = 1'b0;
        end
        else if (ctl.eval && contact)
        begin
            hit_next = 1'b1;
            // later matches override earlier ones on the same axis
            if (m == left)  px_next = box.x0 - rs;
            if (m == right) px_next = box.x1 + rs;
            if (m == front) pz_next = box.z0 - rs;
            if (m == back)  pz_next = box.z1 + rs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        pz_reg <= pz_next;
        py_reg <= py_next;
        r_reg  <= r_next;
        r2_reg <= r2_next;
    end

    assign px  = px_reg;
    assign pz  = pz_reg;
    assign hit = hit_reg;

endmodule

`default_nettype wire

// File: src/sphere_wall_pushout.sv
// Top level: request sequencer around the wall RAM, decode stage and push unit.
// Depends on swp_pkg, swp_ram, swp_box_decode and swp_push_unit.
//
//  channel   dir  signals                      content
//  s_*       in   tvalid tready tdata tuser    one request: action, cell, sphere
//  m_*       out  tvalid tready tdata          one result per request
//
// Clear empties the wall list; add-cell writes one wall per set side bit.
// Resolve sends one stored wall per cycle from the RAM read port, behind a
// read and a decode register, into the push unit; the pass is skipped on an
// empty list. Once the read pipeline drains, the result is loaded.
// Reset clears the wall count but not the RAM; walls are read only below
// the count, so the RAM needs no clearing pass. One request is in work at a
// time; a result that waits on m_tready holds the block in its final state.
`default_nettype none

module sphere_wall_pushout #(
    parameter int MAX_WALLS    = swp_pkg::MAX_WALLS_DEF,
    parameter int THICKNESS_Q8 = swp_pkg::THICKNESS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cell_x[5:0] cell_y[11:6] side_bits[15:12] pos_x[31:16] pos_y[47:32]
    // pos_z[63:48] radius[72:64], zero fill to 80
    input  wire logic [79:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_x[15:0] out_z[31:16] hit_any[32] status[33], zero fill to 40
    output logic [39:0]      m_tdata
);

    import swp_pkg::*;

    localparam int AW = $clog2(MAX_WALLS);
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_WALLS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_RSV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [3:0]      bits_reg, bits_next;
    logic [CXW-1:0]  cx_reg, cx_next;
    logic [CXW-1:0]  cy_reg, cy_next;
    logic [1:0]      act_reg, act_next;
    logic            status_reg, status_next;
    logic            rd_v_reg, rd_v_next;
    logic            dec_v_reg, dec_v_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [39:0]     m_tdata_reg, m_tdata_next;

    logic                 s_acc;
    logic                 issue_v;
    logic                 wr_en;
    logic [1:0]           wr_side;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 load;
    box_t                 box;
    push_ctl_t            push_ctl;
    logic signed [PW-1:0] px, pz;
    logic                 hit;
    logic [15:0]          sat_x, sat_z;

    function automatic logic [15:0] sat16(input logic signed [PW-1:0] v);
        if (v > PW'(32767))
        begin
            return 16'h7FFF;
        end
        else if (v < -PW'(32768))
        begin
            return 16'h8000;
        end
        else
        begin
            return v[15:0];
        end
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // lowest pending side first: north, south, west, east
    always_comb
    begin
        if (bits_reg[0])
        begin
            wr_side = SIDE_N;
        end
        else if (bits_reg[1])
        begin
            wr_side = SIDE_S;
        end
        else if (bits_reg[2])
        begin
            wr_side = SIDE_W;
        end
        else
        begin
            wr_side = SIDE_E;
        end
    end

    // writes only in ST_ADD, valid reads issue only in ST_RSV: no overlap on an entry
    assign wr_en   = (state_reg == ST_ADD) && (count_reg != FULL);
    assign wr_data = {wr_side, cy_reg, cx_reg};
    assign issue_v = (state_reg == ST_RSV) && (idx_reg < count_reg);
    assign load    = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign sat_x   = sat16(px);
    assign sat_z   = sat16(pz);

    assign push_ctl.start = s_acc && (s_tuser == ACT_RESOLVE);
    assign push_ctl.eval  = dec_v_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        bits_next     = bits_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        act_next      = act_reg;
        status_next   = status_reg;
        rd_v_next     = issue_v;
        dec_v_next    = rd_v_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    act_next    = s_tuser;
                    cx_next     = s_tdata[5:0];
                    cy_next     = s_tdata[11:6];
                    bits_next   = s_tdata[15:12];
                    status_next = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_DONE;
                    if (s_tuser == ACT_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (s_tuser == ACT_ADD && s_tdata[15:12] != 4'd0)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (s_tuser == ACT_RESOLVE && count_reg != '0)
                    begin
                        state_next = ST_RSV;
                    end
                end
            end
            ST_ADD:
            begin
                if (wr_en)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    status_next = 1'b1;
                end
                // retire the lowest set bit
                bits_next = bits_reg & (bits_reg - 4'd1);
                if (bits_next == 4'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RSV:
            begin
                if (issue_v)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (!rd_v_reg && !dec_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                if (load)
                begin
                    m_tvalid_next = 1'b1;
                    if (act_reg == ACT_RESOLVE)
                    begin
                        m_tdata_next = {6'd0, 1'b0, hit, sat_z, sat_x};
                    end
                    else if (act_reg == ACT_ADD)
                    begin
                        m_tdata_next = {6'd0, status_reg, 33'd0};
                    end
                    else
                    begin
                        m_tdata_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            bits_reg     <= '0;
            act_reg      <= ACT_CLEAR;
            status_reg   <= 1'b0;
            rd_v_reg     <= 1'b0;
            dec_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            bits_reg     <= bits_next;
            act_reg      <= act_next;
            status_reg   <= status_next;
            rd_v_reg     <= rd_v_next;
            dec_v_reg    <= dec_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        m_tdata_reg <= m_tdata_next;
    end

    swp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WALLS)
    ) u_wall_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    swp_box_decode #(
        .THICKNESS_Q8 (THICKNESS_Q8)
    ) u_decode (
        .clk   (clk),
        .entry (rd_data),
        .box   (box)
    );

    swp_push_unit u_push (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (push_ctl),
        .init_x (s_tdata[31:16]),
        .init_y (s_tdata[47:32]),
        .init_z (s_tdata[63:48]),
        .init_r (s_tdata[72:64]),
        .box    (box),
        .px     (px),
        .pz     (pz),
        .hit    (hit)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_wr_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_ADD)
        else $error("wall write outside add sequence");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("wall count above store depth");

    a_drain_first: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_v_reg || dec_v_reg) |-> state_reg == ST_RSV)
        else $error("read pipeline busy outside resolve");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result overwritten while still pending");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == ACT_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the wall list");

endmodule

`default_nettype wire

// File: tb/swp_checker.sv
// Scoreboard for sphere_wall_pushout: watches both stream channels, keeps its own wall list
// and predicts each result, then compares every returned result field by field.
// Depends on swp_pkg for action and side codes and the wall height.
`timescale 1ns / 100ps

module swp_checker #(
    parameter int WALLS  = swp_pkg::MAX_WALLS_DEF,
    parameter int WALL_T = swp_pkg::THICKNESS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // cell_x[5:0] cell_y[11:6] side_bits[15:12] pos_x[31:16] pos_y[47:32]
    // pos_z[63:48] radius[72:64]
    input  wire logic [79:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // out_x[15:0] out_z[31:16] hit_any[32] status[33]
    input  wire logic [39:0] m_tdata,
    output int               mismatches,
    output int               pending
);

    import swp_pkg::*;

    typedef struct packed {
        logic        status;
        logic        hit_any;
        logic [15:0] out_z;
        logic [15:0] out_x;
    } push_result_t;

    logic [13:0]  wall_mem [WALLS];
    int           wall_total;
    push_result_t result_q [$];
    push_result_t got;
    push_result_t want;
    int           err_count;

    function automatic longint gap_sq(input int c, input int lo, input int hi);
        longint d;
        d = 0;
        if (c < lo)
            d = longint'(c) - lo;
        else if (c > hi)
            d = longint'(c) - hi;
        return d * d;
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic push_result_t predict_request(input logic [1:0] act,
                                                     input logic [79:0] req);
        push_result_t res;
        logic [3:0]   sides;
        logic [13:0]  entry;
        int           side;
        int           px, py, pz, r;
        int           fx, fz, x0, x1, z0, z1;
        int           left, right, front, back, m;
        longint       r_sq, d_sq;
        res = '0;
        case (act)
            ACT_CLEAR:
                wall_total = 0;
            ACT_ADD:
            begin
                sides = req[15:12];
                for (side = 0; side < 4; side++)
                begin
                    if (sides[side])
                    begin
                        if (wall_total < WALLS)
                        begin
                            wall_mem[wall_total] = {2'(side), req[11:6], req[5:0]};
                            wall_total++;
                        end
                        else
                            res.status = 1'b1;
                    end
                end
            end
            ACT_RESOLVE:
            begin
                px   = int'($signed(req[31:16]));
                py   = int'($signed(req[47:32]));
                pz   = int'($signed(req[63:48]));
                r    = int'(req[72:64]);
                r_sq = longint'(r) * r;
                for (int i = 0; i < wall_total && i < WALLS; i++)
                begin
                    entry = wall_mem[i];
                    fx = int'(entry[5:0]) * CELL_Q8;
                    fz = int'(entry[11:6]) * CELL_Q8;
                    case (entry[13:12])
                        SIDE_N:
                        begin
                            x0 = fx; x1 = fx + CELL_Q8; z0 = fz - WALL_T; z1 = fz;
                        end
                        SIDE_S:
                        begin
                            x0 = fx; x1 = fx + CELL_Q8;
                            z0 = fz + CELL_Q8; z1 = fz + CELL_Q8 + WALL_T;
                        end
                        SIDE_W:
                        begin
                            x0 = fx - WALL_T; x1 = fx; z0 = fz; z1 = fz + CELL_Q8;
                        end
                        default:
                        begin
                            x0 = fx + CELL_Q8; x1 = fx + CELL_Q8 + WALL_T;
                            z0 = fz; z1 = fz + CELL_Q8;
                        end
                    endcase
                    d_sq = gap_sq(px, x0, x1) + gap_sq(py, 0, HEIGHT_Q8) + gap_sq(pz, z0, z1);
                    if (d_sq < r_sq)
                    begin
                        res.hit_any = 1'b1;
                        left  = px - x0;
                        right = x1 - px;
                        front = pz - z0;
                        back  = z1 - pz;
                        m = left;
                        if (right < m) m = right;
                        if (front < m) m = front;
                        if (back < m)  m = back;
                        // later matches on the same axis win
                        if (m == left)  px = x0 - r;
                        if (m == right) px = x1 + r;
                        if (m == front) pz = z0 - r;
                        if (m == back)  pz = z1 + r;
                    end
                end
                res.out_x = sat16(px);
                res.out_z = sat16(pz);
            end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            wall_total = 0;
            result_q.delete();
        end
        else
        begin
            // compare before queuing so a stray result cannot consume a fresh request
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[33:0];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, got);
                    err_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    report_field("out_x", want.out_x, got.out_x);
                    report_field("out_z", want.out_z, got.out_z);
                    report_field("hit_any", 16'(want.hit_any), 16'(got.hit_any));
                    report_field("status", 16'(want.status), 16'(got.status));
                end
            end
            if (s_tvalid && s_tready)
                result_q.insert(result_q.size(), predict_request(s_tuser, s_tdata));
        end
        mismatches <= err_count;
        pending    <= result_q.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the sphere_wall_pushout testbench: clock, reset, request stimulus, output stalls,
// watchdog and verdict. Depends on swp_pkg, the block and swp_checker.
`timescale 1ns / 100ps

module testbench;
    import swp_pkg::*;

    localparam int         WALLS       = MAX_WALLS_DEF;
    localparam int         WALL_T      = THICKNESS_DEF;
    localparam int         ITEM_TARGET = 580;
    localparam int         STALL_LIMIT = 6000;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int mismatches;
    int pending;
    int sent;
    int stuck_cycles;
    bit calm;

    sphere_wall_pushout #(
        .MAX_WALLS   (WALLS),
        .THICKNESS_Q8(WALL_T)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    swp_checker #(
        .WALLS (WALLS),
        .WALL_T(WALL_T)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 20);

    function automatic logic [79:0] req_word(input int cx, input int cy, input int sides,
                                             input int px, input int py, input int pz,
                                             input int r);
        return {7'd0, 9'(r), 16'(pz), 16'(py), 16'(px), 4'(sides), 6'(cy), 6'(cx)};
    endfunction

    function automatic logic [79:0] any_word();
        return req_word($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 511));
    endfunction

    // hold valid across back-to-back requests; drop it only for random idle cycles
    task automatic send_req(input logic [1:0] act, input logic [79:0] word);
        calm = (sent >= 360 && sent < 460);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic send_add(input int cx, input int cy, input int sides);
        logic [79:0] word;
        word = any_word();
        word[15:0] = {4'(sides), 6'(cy), 6'(cx)};
        send_req(ACT_ADD, word);
    endtask

    task automatic send_resolve(input int px, input int py, input int pz, input int r);
        send_req(ACT_RESOLVE, req_word($urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 15), px, py, pz, r));
    endtask

    // sphere somewhere around a span x span block of cells at (bx, by)
    task automatic resolve_near(input int bx, input int by, input int span);
        int r;
        if ($urandom_range(0, 3) == 0)
            r = $urandom_range(0, 511);
        else
            r = $urandom_range(0, 160);
        send_resolve(bx * CELL_Q8 + $urandom_range(0, span * CELL_Q8 + 512) - 256,
                     $urandom_range(0, 400) - 80,
                     by * CELL_Q8 + $urandom_range(0, span * CELL_Q8 + 512) - 256, r);
    endtask

    task automatic maze_phase();
        int bx, by, n_cells, n_res;
        bx = $urandom_range(0, 60);
        by = $urandom_range(0, 60);
        send_req(ACT_CLEAR, any_word());
        n_cells = $urandom_range(1, 10);
        repeat (n_cells)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(2'($urandom_range(0, 3)), any_word());
            else
                send_add(bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                         $urandom_range(0, 15));
        end
        n_res = $urandom_range(2, 10);
        repeat (n_res)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(ACT_RESOLVE, any_word());
            else
                resolve_near(bx, by, 4);
        end
    endtask

    // fill the store to the brim, cross the limit mid-request, then resolve against it
    task automatic fill_phase();
        int bx, by;
        bx = $urandom_range(0, 56);
        by = $urandom_range(0, 56);
        send_req(ACT_CLEAR, any_word());
        repeat (WALLS / 4 - 1)
            send_add(bx + $urandom_range(0, 7), by + $urandom_range(0, 7), 15);
        send_add(bx, by, 3);
        send_add(bx + 1, by + 1, 15);
        send_add(bx + 2, by, 0);
        send_add(bx + 3, by, $urandom_range(1, 15));
        send_req(ACT_UNUSED, any_word());
        repeat (6)
            resolve_near(bx, by, 8);
    endtask

    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("sphere_wall_pushout test failed");
        $finish;
    end

    initial
    begin
        sent = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, unused code, extreme cells, single sides
        send_resolve(-32768, 0, 32767, 511);
        send_req(ACT_UNUSED, any_word());
        send_add(0, 0, 15);
        send_add(63, 63, 15);
        send_add(10, 10, 0);
        send_add(3, 3, 1);
        send_add(20, 3, 2);
        send_add(40, 3, 4);
        send_add(50, 3, 8);
        send_resolve(128, 128, 10, 40);
        // exact touch is no hit, nor a sphere above the wall
        send_resolve(128, 128, 40, 40);
        send_resolve(128, 600, 10, 40);
        send_resolve(900, 100, 755, 0);
        send_resolve(900, 100, 755, 1);
        // ties between penetrations
        send_resolve(770, 128, 744, 20);
        send_resolve(-13, 128, 128, 30);
        send_resolve(32767, 32767, -32768, 511);
        send_resolve(16200, 128, 16200, 511);
        send_req(ACT_CLEAR, any_word());
        send_resolve(128, 128, 10, 40);
        send_add(0, 0, 15);
        send_resolve(128, 128, 128, 511);
        send_resolve(128, -511, 128, 511);

        maze_phase();
        maze_phase();
        fill_phase();
        while (sent < ITEM_TARGET)
            maze_phase();
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("sphere_wall_pushout test passed");
        else
            $display("sphere_wall_pushout test failed");
        $finish;
    end

endmodule
